// ===== rtl/sfdi_pkg.sv =====
package sfdi_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEPTH_DEF       = 65536;
  localparam int SAMPLE_BITS_DEF = 24;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY  = 2'd2;

  // Register widths, reset values and limits.
  localparam int WET_W    = 17;
  localparam int GAIN_W   = 16;
  localparam int TDELAY_W = 24;
  localparam int FRAC_W   = 16;

  localparam logic [WET_W-1:0]    WET_RESET    = 17'd32768;
  localparam logic [WET_W-1:0]    WET_MAX      = 17'd65536;
  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd32768;
  localparam logic [GAIN_W-1:0]   GAIN_MAX     = 16'd64225;
  localparam logic [TDELAY_W-1:0] TDELAY_RESET = 24'd6144000;
  localparam logic [TDELAY_W-1:0] TDELAY_MIN   = 24'd256;
  localparam logic [TDELAY_W-1:0] TDELAY_MAX   = 24'd16776704;

  // Smoothed delay: 16 integer bits, 24 fraction bits.
  localparam int SD_INT_W  = 16;
  localparam int SD_FRAC_W = 24;
  localparam int SD_W      = SD_INT_W + SD_FRAC_W;
  localparam int SD_SHIFT  = SD_FRAC_W - 8;

  // Glide coefficient 0.001 in Q0.24, and the split of the 40-bit multiply.
  localparam int               SMOOTH_K_W = 15;
  localparam logic [14:0]      SMOOTH_K   = 15'd16777;
  localparam int               MAG_SPLIT  = 20;

  // Remainder unit: conditional subtracts per cycle and cycle count.
  localparam int RED_STEPS = 4;
  localparam int RED_CYC   = SD_INT_W / RED_STEPS;
  localparam int RED_CNT_W = $clog2(RED_CYC);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRITE,
    S_GLIDE,
    S_RDA,
    S_RDB,
    S_MUL1,
    S_DLY,
    S_MUL3,
    S_FIN,
    S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    G_IDLE,
    G_MAG,
    G_MULLO,
    G_MULHI,
    G_STEP,
    G_RED,
    G_POS
  } glide_state_t;

  // Per-step strobes from the sequencer to both channel lanes.
  typedef struct packed {
    logic load;
    logic we;
    logic cap_a;
    logic mul_d;
    logic dly;
    logic mul_o;
    logic fin;
  } lane_ctrl_t;

endpackage

// ===== rtl/sfdi_ram.sv =====
module sfdi_ram #(
  parameter int WIDTH = sfdi_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = sfdi_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sfdi_glide.sv =====
module sfdi_glide #(
  parameter int DEPTH = sfdi_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sfdi_pkg::TDELAY_W-1:0] target,
  input  logic [AW-1:0]                 wp,
  output logic                          done,
  output logic [AW-1:0]                 x,
  output logic [AW-1:0]                 x1,
  output logic [sfdi_pkg::FRAC_W-1:0]   frac
);

  localparam int SDW  = sfdi_pkg::SD_W;
  localparam int IW   = sfdi_pkg::SD_INT_W;
  localparam int FW   = sfdi_pkg::SD_FRAC_W;
  localparam int KW   = sfdi_pkg::SMOOTH_K_W;
  localparam int SPL  = sfdi_pkg::MAG_SPLIT;
  localparam int CW   = sfdi_pkg::RED_CNT_W;
  localparam int PW   = SPL + KW;
  localparam int SW   = SDW + KW + 1;
  localparam int MW   = IW + AW + 1;
  localparam int PSW  = AW + 1;
  localparam logic [MW-1:0]  DEPTH_M  = MW'(DEPTH);
  localparam logic [SDW-1:0] SD_RESET = SDW'(sfdi_pkg::TDELAY_RESET) << sfdi_pkg::SD_SHIFT;
  localparam logic [SDW-1:0] SD_LO    = SDW'(sfdi_pkg::TDELAY_MIN) << sfdi_pkg::SD_SHIFT;
  localparam logic [SDW-1:0] SD_HI    = SDW'(sfdi_pkg::TDELAY_MAX) << sfdi_pkg::SD_SHIFT;

  sfdi_pkg::glide_state_t state, state_next;

  logic [SDW-1:0] smoothed;
  logic [SDW-1:0] mag;
  logic           up;
  logic [PW-1:0]  prod_lo;
  logic [PW-1:0]  prod_hi;
  logic [IW-1:0]  rem;
  logic [IW-1:0]  rem_next;
  logic [FW-1:0]  fr;
  logic [FW-1:0]  fr_neg;
  logic [CW-1:0]  cnt;

  logic [SDW-1:0] tgt_full;
  logic [SW-1:0]  sum;
  logic [SDW-1:0] step;
  logic [SDW-1:0] sd_new;
  logic [PSW-1:0] pos_i;
  logic [AW-1:0]  x_next;
  logic [AW-1:0]  x1_next;

  assign tgt_full = SDW'(target) << sfdi_pkg::SD_SHIFT;

  // Rounded step: (mag * K + half) >> 24, from two registered partial products.
  assign sum    = SW'(prod_lo) + (SW'(prod_hi) << SPL) + (SW'(1) << (FW - 1));
  assign step   = SDW'(sum >> FW);
  assign sd_new = up ? (smoothed + step) : (smoothed - step);

  // Integer part of the delay modulo DEPTH, a few restoring steps per cycle.
  always_comb begin
    int             ks;
    logic [MW-1:0]  cand;
    rem_next = rem;
    for (int j = 0; j < sfdi_pkg::RED_STEPS; j++) begin
      ks   = int'(cnt) * sfdi_pkg::RED_STEPS + sfdi_pkg::RED_STEPS - 1 - j;
      cand = DEPTH_M << ks;
      if (MW'(rem_next) >= cand) begin
        rem_next = rem_next - IW'(cand);
      end
    end
  end

  // Read position = write pointer - delay, wrapped into the store.
  assign fr_neg  = FW'(0) - fr;
  assign pos_i   = PSW'(wp) - PSW'(rem) - PSW'(|fr);
  assign x_next  = pos_i[AW] ? AW'(pos_i + PSW'(DEPTH)) : pos_i[AW-1:0];
  assign x1_next = (x_next == AW'(DEPTH - 1)) ? '0 : x_next + AW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sfdi_pkg::G_IDLE;
      smoothed <= SD_RESET;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      state <= state_next;
      done  <= (state == sfdi_pkg::G_POS);
      if (state == sfdi_pkg::G_STEP) begin
        smoothed <= sd_new;
        cnt      <= CW'(sfdi_pkg::RED_CYC - 1);
      end else if (state == sfdi_pkg::G_RED) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == sfdi_pkg::G_MAG) begin
      up  <= (smoothed < tgt_full);
      mag <= (smoothed < tgt_full) ? (tgt_full - smoothed) : (smoothed - tgt_full);
    end
    if (state == sfdi_pkg::G_MULLO) begin
      prod_lo <= PW'(mag[SPL-1:0]) * PW'(sfdi_pkg::SMOOTH_K);
    end
    if (state == sfdi_pkg::G_MULHI) begin
      prod_hi <= PW'(mag[SDW-1:SPL]) * PW'(sfdi_pkg::SMOOTH_K);
    end
    if (state == sfdi_pkg::G_STEP) begin
      rem <= sd_new[SDW-1:FW];
      fr  <= sd_new[FW-1:0];
    end
    if (state == sfdi_pkg::G_RED) begin
      rem <= rem_next;
    end
    if (state == sfdi_pkg::G_POS) begin
      x    <= x_next;
      x1   <= x1_next;
      frac <= fr_neg[FW-1 -: sfdi_pkg::FRAC_W];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sfdi_pkg::G_IDLE:  if (start) state_next = sfdi_pkg::G_MAG;
      sfdi_pkg::G_MAG:   state_next = sfdi_pkg::G_MULLO;
      sfdi_pkg::G_MULLO: state_next = sfdi_pkg::G_MULHI;
      sfdi_pkg::G_MULHI: state_next = sfdi_pkg::G_STEP;
      sfdi_pkg::G_STEP:  state_next = sfdi_pkg::G_RED;
      sfdi_pkg::G_RED:   if (cnt == '0) state_next = sfdi_pkg::G_POS;
      sfdi_pkg::G_POS:   state_next = sfdi_pkg::G_IDLE;
      default:           state_next = sfdi_pkg::G_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  // The smoothed delay never leaves the span of legal targets.
  a_sd_range: assert property (@(posedge clk) disable iff (rst)
    (smoothed >= SD_LO) && (smoothed <= SD_HI))
    else $error("smoothed delay out of range");

  // The remainder is fully reduced before the position is formed.
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == sfdi_pkg::G_POS) |-> (MW'(rem) < DEPTH_M))
    else $error("delay not reduced modulo store depth");

  // Both read indices lie inside the store when handed over.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((PSW'(x) < PSW'(DEPTH)) && (PSW'(x1) < PSW'(DEPTH))))
    else $error("read index outside store");
`endif

endmodule

// ===== rtl/sfdi_lane.sv =====
module sfdi_lane #(
  parameter int DEPTH       = sfdi_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = sfdi_pkg::SAMPLE_BITS_DEF,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sfdi_pkg::lane_ctrl_t        ctrl,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic [AW-1:0]               waddr,
  input  logic [AW-1:0]               raddr,
  input  logic                        rd_valid,
  input  logic [sfdi_pkg::FRAC_W-1:0] frac,
  input  logic [sfdi_pkg::GAIN_W-1:0] gain,
  input  logic [sfdi_pkg::WET_W-1:0]  wet,
  output logic [SAMPLE_BITS-1:0]      result
);

  localparam int SB  = SAMPLE_BITS;
  localparam int DW  = SB + 18;
  localparam int GW  = SB + 17;
  localparam int MSW = SB + 19;
  localparam int MXW = MSW - 16;
  localparam int WSW = SB + 1;

  localparam logic signed [WSW-1:0] W_MAX = {2'b00, {(SB-1){1'b1}}};
  localparam logic signed [WSW-1:0] W_MIN = {2'b11, {(SB-1){1'b0}}};
  localparam logic signed [MXW-1:0] M_MAX = {{(MXW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [MXW-1:0] M_MIN = {{(MXW-SB+1){1'b1}}, {(SB-1){1'b0}}};
  localparam logic signed [DW-1:0]  HALF_D = DW'(32768);
  localparam logic signed [GW-1:0]  HALF_G = GW'(32768);
  localparam logic signed [MSW-1:0] HALF_M = MSW'(32768);

  logic signed [SB-1:0]  in_q;
  logic signed [SB-1:0]  fb;
  logic signed [SB-1:0]  a;
  logic signed [SB-1:0]  dl;
  logic signed [SB-1:0]  rd_word;
  logic [SB-1:0]         rdata;
  logic [SB-1:0]         wdata;
  logic                  rv_q;
  logic signed [WSW-1:0] wsum;
  logic signed [SB:0]    diff;
  logic signed [DW-1:0]  prod_d;
  logic signed [DW-1:0]  rnd_d;
  logic signed [GW-1:0]  pg;
  logic signed [GW-1:0]  rnd_g;
  logic signed [DW-1:0]  pd;
  logic signed [DW-1:0]  pw;
  logic signed [MSW-1:0] msum;
  logic signed [MXW-1:0] mix_sh;
  logic [sfdi_pkg::WET_W-1:0] wet_inv;

  // Store entry is the input plus last feedback, saturated.
  assign wsum  = in_q + fb;
  assign wdata = (wsum > W_MAX) ? W_MAX[SB-1:0] :
                 (wsum < W_MIN) ? W_MIN[SB-1:0] : wsum[SB-1:0];

  sfdi_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctrl.we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Entries not yet written read as zero.
  assign rd_word = rv_q ? $signed(rdata) : '0;
  assign diff    = rd_word - a;
  assign rnd_d   = (prod_d + HALF_D) >>> 16;
  assign wet_inv = sfdi_pkg::WET_MAX - wet;
  assign rnd_g   = (pg + HALF_G) >>> 16;
  assign msum    = pd + pw + HALF_M;
  assign mix_sh  = MXW'(msum >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      fb <= '0;
    end else if (ctrl.fin) begin
      fb <= rnd_g[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rv_q <= rd_valid;
    if (ctrl.load) begin
      in_q <= in_sample;
    end
    if (ctrl.cap_a) begin
      a <= rd_word;
    end
    if (ctrl.mul_d) begin
      prod_d <= diff * $signed({1'b0, frac});
    end
    if (ctrl.dly) begin
      dl <= a + rnd_d[SB-1:0];
    end
    if (ctrl.mul_o) begin
      pg <= dl * $signed({1'b0, gain});
      pd <= in_q * $signed({1'b0, wet_inv});
      pw <= dl * $signed({1'b0, wet});
    end
    if (ctrl.fin) begin
      result <= (mix_sh > M_MAX) ? M_MAX[SB-1:0] :
                (mix_sh < M_MIN) ? M_MIN[SB-1:0] : mix_sh[SB-1:0];
    end
  end

endmodule

// ===== rtl/stereo_feedback_delay_interp_top.sv =====
// Pairs are taken one at a time: s_axis_tready is high only while the sequencer is idle, so a
// new pair waits until the last result has gone to the output register. Each item is paced by
// the glide unit (two partial products of the 40-bit smoothing multiply, then the remainder
// steps) and two reads per channel on the one read port of each delay store.
// Reset: synchronous, active high; clears control, pointers and feedback and loads the register
// reset values. The stores need no clearing pass and accept transfers straight after reset.
module stereo_feedback_delay_interp_top #(
  parameter int DEPTH       = sfdi_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = sfdi_pkg::SAMPLE_BITS_DEF,
  localparam int AW         = $clog2(DEPTH),
  localparam int TDW        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream: in_left [SAMPLE_BITS-1:0], in_right above it, zero padding on top.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [TDW-1:0]                  s_axis_tdata,
  // Output stream: out_left [SAMPLE_BITS-1:0], out_right above it, zero padding on top.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [TDW-1:0]                  m_axis_tdata,
  // Configuration writes: wet_mix, feedback_gain, target_delay at indices 0, 1, 2.
  input  logic                            cfg_we,
  input  logic [sfdi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfdi_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SB = SAMPLE_BITS;

  sfdi_pkg::seq_state_t state, state_next;
  sfdi_pkg::lane_ctrl_t lc;

  logic [sfdi_pkg::WET_W-1:0]    wet_mix;
  logic [sfdi_pkg::GAIN_W-1:0]   feedback_gain;
  logic [sfdi_pkg::TDELAY_W-1:0] target_delay;
  logic [sfdi_pkg::WET_W-1:0]    wet_c;
  logic [sfdi_pkg::GAIN_W-1:0]   gain_c;
  logic [sfdi_pkg::TDELAY_W-1:0] tgt_c;

  logic [AW-1:0]               wp;
  logic                        full;
  logic                        g_start;
  logic                        g_done;
  logic [AW-1:0]               g_x;
  logic [AW-1:0]               g_x1;
  logic [sfdi_pkg::FRAC_W-1:0] g_frac;
  logic [AW-1:0]               raddr;
  logic                        rd_valid;
  logic                        out_free;
  logic                        in_xfer;
  logic [SB-1:0]               res_l;
  logic [SB-1:0]               res_r;

  // Out-of-range register values are clamped where they are used, so a write is stored as given.
  assign wet_c  = (wet_mix > sfdi_pkg::WET_MAX) ? sfdi_pkg::WET_MAX : wet_mix;
  assign gain_c = (feedback_gain > sfdi_pkg::GAIN_MAX) ? sfdi_pkg::GAIN_MAX : feedback_gain;
  assign tgt_c  = (target_delay < sfdi_pkg::TDELAY_MIN) ? sfdi_pkg::TDELAY_MIN :
                  (target_delay > sfdi_pkg::TDELAY_MAX) ? sfdi_pkg::TDELAY_MAX : target_delay;

  assign s_axis_tready = (state == sfdi_pkg::S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // The stores are filled from index zero upwards. Until the write pointer first wraps, an entry
  // above the pointer has never been written and reads as zero, which stands in for clearing
  // the memories after reset. The entry at the pointer itself was written earlier in this item.
  assign rd_valid = full || (raddr <= wp);

  always_ff @(posedge clk) begin
    if (rst) begin
      wet_mix       <= sfdi_pkg::WET_RESET;
      feedback_gain <= sfdi_pkg::GAIN_RESET;
      target_delay  <= sfdi_pkg::TDELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfdi_pkg::CFG_WET_MIX:       wet_mix       <= cfg_data[sfdi_pkg::WET_W-1:0];
        sfdi_pkg::CFG_FEEDBACK_GAIN: feedback_gain <= cfg_data[sfdi_pkg::GAIN_W-1:0];
        sfdi_pkg::CFG_TARGET_DELAY:  target_delay  <= cfg_data[sfdi_pkg::TDELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state, write pointer, fill flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sfdi_pkg::S_IDLE;
      wp            <= '0;
      full          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == sfdi_pkg::S_FIN) begin
        if (wp == AW'(DEPTH - 1)) begin
          wp   <= '0;
          full <= 1'b1;
        end else begin
          wp <= wp + AW'(1);
        end
      end
      if ((state == sfdi_pkg::S_OUT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Merge stage: the two lane results are packed into the output register.
  always_ff @(posedge clk) begin
    if ((state == sfdi_pkg::S_OUT) && out_free) begin
      m_axis_tdata <= TDW'({res_r, res_l});
    end
  end

  // Each item: store write, glide and position, read the two neighbours,
  // interpolate, the three gain products, then round, saturate and hand over.
  always_comb begin
    state_next = state;
    lc         = '0;
    lc.load    = in_xfer;
    g_start    = 1'b0;
    raddr      = g_x;
    unique case (state)
      sfdi_pkg::S_IDLE: begin
        if (in_xfer) state_next = sfdi_pkg::S_WRITE;
      end
      sfdi_pkg::S_WRITE: begin
        lc.we      = 1'b1;
        g_start    = 1'b1;
        state_next = sfdi_pkg::S_GLIDE;
      end
      sfdi_pkg::S_GLIDE: begin
        if (g_done) state_next = sfdi_pkg::S_RDA;
      end
      sfdi_pkg::S_RDA: begin
        state_next = sfdi_pkg::S_RDB;
      end
      sfdi_pkg::S_RDB: begin
        raddr      = g_x1;
        lc.cap_a   = 1'b1;
        state_next = sfdi_pkg::S_MUL1;
      end
      sfdi_pkg::S_MUL1: begin
        lc.mul_d   = 1'b1;
        state_next = sfdi_pkg::S_DLY;
      end
      sfdi_pkg::S_DLY: begin
        lc.dly     = 1'b1;
        state_next = sfdi_pkg::S_MUL3;
      end
      sfdi_pkg::S_MUL3: begin
        lc.mul_o   = 1'b1;
        state_next = sfdi_pkg::S_FIN;
      end
      sfdi_pkg::S_FIN: begin
        lc.fin     = 1'b1;
        state_next = sfdi_pkg::S_OUT;
      end
      sfdi_pkg::S_OUT: begin
        if (out_free) state_next = sfdi_pkg::S_IDLE;
      end
      default: state_next = sfdi_pkg::S_IDLE;
    endcase
  end

  // Shared delay glide and read position, used by both channels.
  sfdi_glide #(
    .DEPTH (DEPTH)
  ) u_glide (
    .clk    (clk),
    .rst    (rst),
    .start  (g_start),
    .target (tgt_c),
    .wp     (wp),
    .done   (g_done),
    .x      (g_x),
    .x1     (g_x1),
    .frac   (g_frac)
  );

  sfdi_lane #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SB)
  ) u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lc),
    .in_sample (s_axis_tdata[SB-1:0]),
    .waddr     (wp),
    .raddr     (raddr),
    .rd_valid  (rd_valid),
    .frac      (g_frac),
    .gain      (gain_c),
    .wet       (wet_c),
    .result    (res_l)
  );

  sfdi_lane #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SB)
  ) u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lc),
    .in_sample (s_axis_tdata[2*SB-1:SB]),
    .waddr     (wp),
    .raddr     (raddr),
    .rd_valid  (rd_valid),
    .frac      (g_frac),
    .gain      (gain_c),
    .wet       (wet_c),
    .result    (res_r)
  );

`ifndef NO_ASSERTIONS
  // The glide unit only finishes while the sequencer is waiting for it.
  a_glide_sync: assert property (@(posedge clk) disable iff (rst)
    g_done |-> (state == sfdi_pkg::S_GLIDE))
    else $error("glide result arrived outside the wait state");

  // Once the stores have wrapped, every entry stays valid.
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("store fill flag dropped");

  // Every finished item moves the write pointer on.
  a_wp_moves: assert property (@(posedge clk) disable iff (rst)
    (state == sfdi_pkg::S_FIN) |=> (wp != $past(wp)))
    else $error("write pointer did not advance");
`endif

endmodule

// ===== bench/stereo_feedback_delay_interp_top_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the stereo feedback delay. Every accepted input pair is run
// through a behavioural copy of the delay line kept in this module (its own stores,
// write position, gliding delay and feedback), and the expected mix, or a typed row's
// own values, is queued. Output transfers are compared field by field, oldest first.
module stereo_feedback_delay_interp_top_tb;

  import sfdi_pkg::*;

  localparam int DATA_W      = 48;
  localparam int STORE_DEPTH = 65536;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 20;   // a little over the block's latency
  localparam int DRAIN       = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int NROWS       = 24;
  localparam int NPHASE      = 12;
  localparam int PHASE_LEN   = 150;
  localparam int WARM_CAP    = 6000;
  localparam int LOUD_PHASE  = 2;
  localparam int HOLD_PHASE  = 3;
  localparam int PAUSE_PHASE = 6;

  // The register map has room for a fourth index that no register uses.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Glide coefficient (0.001 in Q0.24) and the rounding half for the 24-bit shift.
  localparam logic [63:0] GLIDE_COEF = 64'd16777;
  localparam logic [63:0] ROUND24    = 64'd8388608;

  typedef logic signed [23:0] sample_t;

  localparam sample_t SMAX   = 24'h7FFFFF;
  localparam sample_t SMIN   = 24'h800000;
  localparam longint  SMAX_L = 8388607;
  localparam longint  SMIN_L = -8388608;

  typedef struct packed {
    sample_t l;
    sample_t r;
  } mix_t;

  typedef enum logic {ROW_PAIR, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    sample_t               l;
    sample_t               r;
    logic                  typed;
    sample_t               el;
    sample_t               er;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [DATA_W-1:0]     s_axis_tdata;   // in_left [23:0], in_right [47:24]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [DATA_W-1:0]     m_axis_tdata;   // out_left [23:0], out_right [47:24]
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Behavioural copy of the delay line and of the register file.
  sample_t     echo_l [STORE_DEPTH];
  sample_t     echo_r [STORE_DEPTH];
  logic [15:0] wr_head;
  logic [39:0] smooth_q;      // smoothed delay, 16 integer and 24 fraction bits
  sample_t     fb_l;
  sample_t     fb_r;
  logic [16:0] wet_mirror;
  logic [15:0] gain_mirror;
  logic [23:0] delay_mirror;

  mix_t pending [$];

  int  mismatches   = 0;
  int  results_seen = 0;
  int  cycle_count  = 0;
  int  pairs_sent   = 0;
  bit  src_idle_on  = 1'b0;
  bit  sink_idle_on = 1'b0;
  bit  hold_start   = 1'b0;

  stereo_feedback_delay_interp_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ------------------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------------------

  function automatic sample_t clip(input longint v);
    if (v > SMAX_L) return SMAX;
    if (v < SMIN_L) return SMIN;
    return sample_t'(v);
  endfunction

  // Linear interpolation with a Q0.16 fraction, rounded half up.
  function automatic longint lerp(input longint a, input longint b, input logic [15:0] frac);
    longint fl;
    fl = frac;
    return a + (((b - a) * fl + 32768) >>> 16);
  endfunction

  // One stereo pair through the delay line: glide, write, interpolated read, feedback
  // update and dry/wet mix, in that order.
  function automatic mix_t predict_mix(input sample_t in_l, input sample_t in_r);
    logic [23:0] tgt24;
    logic [39:0] tgt;
    logic [39:0] gap;
    logic [39:0] nudge;
    logic [39:0] tap;
    logic [63:0] prod;
    logic [15:0] xa;
    logic [15:0] xb;
    logic [15:0] frac;
    longint      wet;
    longint      gain;
    longint      il;
    longint      ir;
    longint      dl;
    longint      dr;
    mix_t        res;

    tgt24 = delay_mirror;
    if (tgt24 < TDELAY_MIN) tgt24 = TDELAY_MIN;
    else if (tgt24 > TDELAY_MAX) tgt24 = TDELAY_MAX;
    tgt  = {tgt24, 16'd0};
    wet  = (wet_mirror > WET_MAX) ? WET_MAX : wet_mirror;
    gain = (gain_mirror > GAIN_MAX) ? GAIN_MAX : gain_mirror;

    // The glide step is rounded on its magnitude, so it never overshoots the target.
    gap      = (smooth_q >= tgt) ? smooth_q - tgt : tgt - smooth_q;
    prod     = {24'd0, gap} * GLIDE_COEF + ROUND24;
    nudge    = prod[63:24];
    smooth_q = (smooth_q >= tgt) ? smooth_q - nudge : smooth_q + nudge;

    il = in_l;
    ir = in_r;
    echo_l[wr_head] = clip(il + fb_l);
    echo_r[wr_head] = clip(ir + fb_r);

    // Forty-bit wrap of the read position is the modulo over the whole store.
    tap  = {wr_head, 24'd0} - smooth_q;
    xa   = tap[39:24];
    xb   = xa + 16'd1;
    frac = tap[23:8];
    dl   = lerp(echo_l[xa], echo_l[xb], frac);
    dr   = lerp(echo_r[xa], echo_r[xb], frac);

    fb_l  = sample_t'((dl * gain + 32768) >>> 16);
    fb_r  = sample_t'((dr * gain + 32768) >>> 16);
    res.l = clip((il * (65536 - wet) + dl * wet + 32768) >>> 16);
    res.r = clip((ir * (65536 - wet) + dr * wet + 32768) >>> 16);

    wr_head = wr_head + 16'd1;
    return res;
  endfunction

  // ------------------------------------------------------------------------------------
  // Directed table
  // ------------------------------------------------------------------------------------

  function automatic plan_row_t pair_row(input sample_t l, input sample_t r, input logic typed,
                                         input sample_t el, input sample_t er);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_PAIR;
    row.l     = l;
    row.r     = r;
    row.typed = typed;
    row.el    = el;
    row.er    = er;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  // Early on the delay is still some 24000 samples, so every read lands on entries that
  // have never been written and the wet path is silent: the output is the dry share
  // alone, which is what the typed rows rely on.
  function automatic plan_row_t plan_row(input int i);
    case (i)
      0:  return pair_row(0, 0, 1'b1, 0, 0);
      1:  return pair_row(SMAX, SMIN, 1'b1, 4194304, -4194304);
      2:  return pair_row(SMIN, SMAX, 1'b1, -4194304, 4194304);
      3:  return pair_row(1, -1, 1'b1, 1, 0);
      4:  return reg_row(CFG_WET_MIX, 0);
      5:  return pair_row(SMAX, SMIN, 1'b1, SMAX, SMIN);
      6:  return pair_row(123456, -654321, 1'b1, 123456, -654321);
      7:  return reg_row(CFG_WET_MIX, WET_MAX);
      8:  return pair_row(SMAX, SMIN, 1'b1, 0, 0);
      // Wet above range: the low 17 bits read as 131071, which counts as fully wet.
      9:  return reg_row(CFG_WET_MIX, 24'hFFFFFF);
      10: return pair_row(-5, 77777, 1'b1, 0, 0);
      // A write to the spare index must leave the mix fully wet.
      11: return reg_row(CFG_SPARE, 0);
      12: return pair_row(SMAX, SMAX, 1'b1, 0, 0);
      13: return reg_row(CFG_FEEDBACK_GAIN, 24'h00FFFF);
      14: return reg_row(CFG_TARGET_DELAY, 0);
      15: return pair_row(1000, -1000, 1'b1, 0, 0);
      16: return reg_row(CFG_WET_MIX, 16384);
      17: return pair_row(SMAX, SMIN, 1'b0, 0, 0);
      18: return reg_row(CFG_TARGET_DELAY, 24'hFFFFFF);
      19: return pair_row(SMIN, SMAX, 1'b0, 0, 0);
      20: return reg_row(CFG_FEEDBACK_GAIN, 0);
      21: return pair_row(4194304, -4194304, 1'b0, 0, 0);
      22: return reg_row(CFG_TARGET_DELAY, TDELAY_MAX);
      default: return pair_row(-1, 1, 1'b0, 0, 0);
    endcase
  endfunction

  // Mostly full-range values, with the extremes and small values around zero mixed in.
  // A loud draw is mostly full scale, to drive the stores into saturation.
  function automatic sample_t pick_sample(input bit loud);
    logic [23:0] v;
    v = $urandom();
    if (loud && $urandom_range(0, 4) != 0) return ($urandom_range(0, 1) != 0) ? SMAX : SMIN;
    case ($urandom_range(0, 9))
      0:       return SMAX;
      1:       return SMIN;
      2: begin
        v = $urandom_range(0, 64) - 32;
        return v;
      end
      default: return v;
    endcase
  endfunction

  // ------------------------------------------------------------------------------------
  // Driving tasks
  // ------------------------------------------------------------------------------------

  // Offers one pair, optionally after a short idle burst, and waits for the transfer.
  // The valid stays high afterwards; the next call decides whether it drops.
  task automatic push_pair(input sample_t l, input sample_t r, input logic typed,
                           input sample_t el, input sample_t er);
    mix_t want;
    int   gap;
    @(negedge clk);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {r, l};
    do @(posedge clk); while (!s_axis_tready);
    want = predict_mix(l, r);
    if (typed) begin
      want.l = el;
      want.r = er;
    end
    pending.push_back(want);
    pairs_sent++;
  endtask

  // Register writes happen only with the block idle: input withdrawn, every result in,
  // and a short settle after that.
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_WET_MIX:       wet_mirror   = val[WET_W-1:0];
      CFG_FEEDBACK_GAIN: gain_mirror  = val[GAIN_W-1:0];
      CFG_TARGET_DELAY:  delay_mirror = val[TDELAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= 60)
      $display("mismatch on result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
  endtask

  // ------------------------------------------------------------------------------------
  // Output side: ready pattern and result check
  // ------------------------------------------------------------------------------------

  // The ready pattern is kept in its own process. A requested hold-off is counted here
  // in cycles while the sender keeps offering pairs, so the block fills and backs up.
  initial begin
    int hold_left;
    int burst_left;
    hold_left     = 0;
    burst_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        m_axis_tready = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        burst_left    = $urandom_range(0, 3);
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    mix_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending.size() == 0) begin
        note_mismatch("unexpected result, left", $signed(m_axis_tdata[23:0]), 0);
      end else begin
        want = pending.pop_front();
        if ($signed(m_axis_tdata[23:0]) !== want.l)
          note_mismatch("out_left", $signed(m_axis_tdata[23:0]), want.l);
        if ($signed(m_axis_tdata[47:24]) !== want.r)
          note_mismatch("out_right", $signed(m_axis_tdata[47:24]), want.r);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------------------

  initial begin
    int          i;
    int          ph;
    int          k;
    int          warm_pairs;
    int          random_pairs;
    int          table_pairs;
    plan_row_t   row;
    logic [23:0] word;
    logic [16:0] wet_v;
    logic [15:0] gain_v;
    logic [23:0] tgt_v;
    bit          loud;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_WET_MIX;
    cfg_data      = '0;
    warm_pairs    = 0;
    random_pairs  = 0;

    for (i = 0; i < STORE_DEPTH; i++) begin
      echo_l[i] = '0;
      echo_r[i] = '0;
    end
    wr_head      = '0;
    smooth_q     = {TDELAY_RESET, 16'd0};
    fb_l         = '0;
    fb_r         = '0;
    wet_mirror   = WET_RESET;
    gain_mirror  = GAIN_RESET;
    delay_mirror = TDELAY_RESET;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table, with light idling on both sides.
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    for (i = 0; i < NROWS; i++) begin
      row = plan_row(i);
      if (row.kind == ROW_REG) set_reg(row.idx, row.val);
      else push_pair(row.l, row.r, row.typed, row.el, row.er);
    end
    table_pairs = pairs_sent;

    // Run-in: the smoothed delay leaves reset at 24000 samples and only glides by a
    // thousandth of the distance per pair. With the shortest target it is pulled down
    // until reads land well inside the written part of the stores; only from then on
    // do interpolation and feedback carry real data.
    set_reg(CFG_WET_MIX, 17'd40000);
    set_reg(CFG_FEEDBACK_GAIN, GAIN_MAX);
    set_reg(CFG_TARGET_DELAY, TDELAY_MIN);
    while (int'(smooth_q[39:24]) * 2 > int'(wr_head) && warm_pairs < WARM_CAP) begin
      push_pair(pick_sample(1'b0), pick_sample(1'b0), 1'b0, 0, 0);
      warm_pairs++;
    end

    // Random phases, each under its own register setting. Targets stay short so that the
    // delay keeps reading written data; the two last phases push it to the top of its
    // range and beyond, and run without any idling.
    for (ph = 0; ph < NPHASE; ph++) begin
      case ($urandom_range(0, 5))
        0:       wet_v = 17'd0;
        1:       wet_v = WET_MAX;
        2:       wet_v = $urandom_range(65537, 131071);
        default: wet_v = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 5))
        0:       gain_v = 16'd0;
        1:       gain_v = GAIN_MAX;
        2:       gain_v = $urandom_range(64226, 65535);
        default: gain_v = $urandom_range(0, 64225);
      endcase
      case ($urandom_range(0, 4))
        0:       tgt_v = $urandom_range(0, 255);
        1:       tgt_v = TDELAY_MIN;
        default: tgt_v = $urandom_range(256, 256 * 300);
      endcase
      loud = (ph == LOUD_PHASE);
      if (loud) gain_v = GAIN_MAX;
      if (ph == NPHASE - 2) tgt_v = TDELAY_MAX;
      if (ph == NPHASE - 1) tgt_v = 24'hFFFFFF;

      // Unused upper bits of the write data are filled at random; they must be ignored.
      word = $urandom();
      word[WET_W-1:0] = wet_v;
      set_reg(CFG_WET_MIX, word);
      word = $urandom();
      word[GAIN_W-1:0] = gain_v;
      set_reg(CFG_FEEDBACK_GAIN, word);
      set_reg(CFG_TARGET_DELAY, tgt_v);

      src_idle_on  = (ph < NPHASE - 2) && (ph % 3 != 1) && (ph != HOLD_PHASE);
      sink_idle_on = (ph < NPHASE - 2) && (ph % 3 != 1);
      if (ph == HOLD_PHASE) begin
        @(posedge clk);
        hold_start = 1'b1;
      end

      for (k = 0; k < PHASE_LEN; k++) begin
        // Mid-phase, the sender stops until every outstanding result is back.
        if (ph == PAUSE_PHASE && k == PHASE_LEN / 2) begin
          @(negedge clk);
          s_axis_tvalid = 1'b0;
          while (pending.size() != 0) @(negedge clk);
        end
        push_pair(pick_sample(loud), pick_sample(loud), 1'b0, 0, 0);
        random_pairs++;
      end
    end

    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d stereo transfers: %0d from the table, %0d in the glide run-in, %0d random",
             pairs_sent, table_pairs, warm_pairs, random_pairs);
    $display("over %0d register settings; %0d results compared, final delay %0d samples.",
             NPHASE, results_seen, smooth_q[39:24]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sfdi_pkg.sv
rtl/sfdi_ram.sv
rtl/sfdi_glide.sv
rtl/sfdi_lane.sv
rtl/stereo_feedback_delay_interp_top.sv
bench/stereo_feedback_delay_interp_top_tb.sv
